// ----- rtl/core/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes for the sorted timer queue
// Holds the request and result word layouts, operation, kind and status
// codes, and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package stq_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 10;
    localparam int IN_TIME_W = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } stq_op_t;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_NONE    = 2'd2
    } stq_kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUPLICATE = 2'd3
    } stq_status_t;

    // request word
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [HANDLE_W-1:0]  handle;
        logic [IN_TIME_W-1:0] expire;
        logic [IN_TIME_W-1:0] now;
    } stq_in_t;

    // result word
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] expired_handle;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [OCC_W-1:0]    occupancy;
    } stq_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic        load;      // capture the request word
        logic        remove;    // remove the entry that matches the handle
        logic        pop;       // remove the head entry
        logic        insert;    // insert the captured handle and expiry
        logic        emit;      // load the result register
        stq_kind_t   kind;
        stq_status_t status;
        logic        last;
    } stq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        stq_op_t op;         // captured operation
        logic    found;      // captured handle is held
        logic    full;       // table is full
        logic    head_due;   // head entry has expired
        logic    pop_last;   // popping the head leaves nothing due
    } stq_stat_t;

endpackage

// ----- rtl/core/stq_datapath.sv -----
// ----------------------------------------------------------------------------
// stq_datapath: sorted timer array and result register
// Keeps expiry/handle entries sorted in a row of registers; every entry
// compares in parallel and shifts one place per insert or remove.
// ----------------------------------------------------------------------------
module stq_datapath
    import stq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
)(
    input  logic      clk,
    input  logic      rst_n,
    input  stq_in_t   request,
    input  stq_cmd_t  cmd,
    output stq_stat_t stat,
    output logic      result_valid,
    output stq_out_t  result
);

    localparam int TW = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // entry storage, only the first count entries are meaningful
    logic [TW-1:0]       exp_reg  [DEPTH];
    logic [TW-1:0]       exp_next [DEPTH];
    logic [HANDLE_W-1:0] hnd_reg  [DEPTH];
    logic [HANDLE_W-1:0] hnd_next [DEPTH];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    // captured request
    stq_op_t             op_reg;
    logic [HANDLE_W-1:0] req_hnd_reg;
    logic [TW-1:0]       req_exp_reg;
    logic [TW-1:0]       req_now_reg;

    logic                result_valid_reg;
    stq_out_t            result_reg;
    stq_out_t            result_next;

    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    le;
    logic [IW-1:0]       match_pos;
    logic [IW-1:0]       rm_pos;

    // per-entry compares
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CW'(i) < count_reg) && (hnd_reg[i] == req_hnd_reg);
            le[i]    = (CW'(i) < count_reg) && (exp_reg[i] <= req_exp_reg);
        end
    end

    // position of the matching entry, handles are unique
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match_pos = match_pos | (match[i] ? IW'(i) : '0);
        end
    end

    assign rm_pos = cmd.pop ? '0 : match_pos;

    // status to controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.found    = |match;
        stat.full     = (count_reg == CW'(DEPTH));
        stat.head_due = (count_reg != '0) && (exp_reg[0] <= req_now_reg);
        stat.pop_last = (count_reg == CW'(1)) || (exp_reg[1] > req_now_reg);
    end

    // shift network for remove and insert
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            exp_next[i] = exp_reg[i];
            hnd_next[i] = hnd_reg[i];
        end
        count_next = count_reg;
        if (cmd.remove || cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (IW'(i) >= rm_pos)
                begin
                    exp_next[i] = exp_reg[i + 1];
                    hnd_next[i] = hnd_reg[i + 1];
                end
            end
            count_next = count_reg - CW'(1);
        end
        else if (cmd.insert)
        begin
            if (!le[0])
            begin
                exp_next[0] = req_exp_reg;
                hnd_next[0] = req_hnd_reg;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!le[i])
                begin
                    if (le[i - 1])
                    begin
                        exp_next[i] = req_exp_reg;
                        hnd_next[i] = req_hnd_reg;
                    end
                    else
                    begin
                        exp_next[i] = exp_reg[i - 1];
                        hnd_next[i] = hnd_reg[i - 1];
                    end
                end
            end
            count_next = count_reg + CW'(1);
        end
    end

    // result word
    always_comb
    begin
        result_next.kind           = cmd.kind;
        result_next.expired_handle = (cmd.kind == KIND_EXPIRED) ? hnd_reg[0] : '0;
        result_next.status         = cmd.status;
        result_next.last           = cmd.last;
        result_next.occupancy      = OCC_W'(count_next);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            exp_reg[i] <= exp_next[i];
            hnd_reg[i] <= hnd_next[i];
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= stq_op_t'(request.op);
            req_hnd_reg <= request.handle;
            req_exp_reg <= request.expire[TW-1:0];
            req_now_reg <= request.now[TW-1:0];
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    // fill count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= cmd.emit;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/stq_ctrl.sv -----
// ----------------------------------------------------------------------------
// stq_ctrl: operation sequencer for the sorted timer queue
// Steps each operation through lookup, move and result emission; a tick
// pops expired head entries one per cycle.
// ----------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  stq_stat_t stat,
    output stq_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_INSERT = 4'b0100,
        S_TICK   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_ACK;
        cmd.status = ST_OK;
        cmd.last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_INSERT:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.found)
                        begin
                            cmd.status = ST_DUPLICATE;
                        end
                        else if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    OP_ADJUST:
                    begin
                        if (stat.found)
                        begin
                            cmd.remove = 1'b1;
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                    end
                    OP_DELETE:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.found)
                        begin
                            cmd.remove = 1'b1;
                        end
                        else
                        begin
                            cmd.status = ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.head_due)
                        begin
                            cmd.pop    = 1'b1;
                            cmd.kind   = KIND_EXPIRED;
                            cmd.last   = stat.pop_last;
                            state_next = stat.pop_last ? S_IDLE : S_TICK;
                        end
                        else
                        begin
                            cmd.kind   = KIND_NONE;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_TICK:
            begin
                cmd.pop    = 1'b1;
                cmd.emit   = 1'b1;
                cmd.kind   = KIND_EXPIRED;
                cmd.last   = stat.pop_last;
                state_next = stat.pop_last ? S_IDLE : S_TICK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/core/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue: ascending sorted timer list
// Holds up to DEPTH timers sorted by expiry, with insert, adjust, delete and
// tick operations.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the word is taken at a clock edge where
//   start is high and busy is low. Results come out on result, each marked
//   by result_valid for exactly one cycle; result.last flags the final word
//   of an operation. The receiver cannot stall the block.
//   Result words of each operation, after the word is taken:
//     insert, delete         one result
//     adjust                 remove pass, then insert pass, one result
//     tick                   one result per expired timer (a none word if
//                            none is due), results on consecutive cycles
//   busy falls as the last result is loaded, so a new word can be taken
//   while that result is shown. Each insert or remove is one parallel
//   compare-and-shift pass over the entry row; a tick pops one head entry
//   per cycle.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  stq_in_t  request,
    output logic     result_valid,
    output stq_out_t result
);

    stq_cmd_t  cmd;
    stq_stat_t stat;

    // sequencer
    stq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // sorted entry row
    stq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- rtl/core/stq_checker.sv -----
// ----------------------------------------------------------------------------
// stq_checker: port-level checks for the sorted timer queue
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker
    import stq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     result_valid,
    input stq_out_t result
);

    // an accepted word makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("busy did not rise after an accepted word");

    // the block only goes idle by showing a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
    else $error("busy fell without a result word");

    // a final word is followed by a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
    else $error("result word right after a final word");

    // expired words of one tick come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && result.kind == KIND_EXPIRED)
    else $error("gap inside an expired word train");

    // only acknowledge words carry a nonzero status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_ACK |-> result.status == ST_OK)
    else $error("tick word with nonzero status");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_timer_queue
// Keeps its own ascending timer list in a scoreboard and predicts every result
// word. A short directed run covers empty ticks, unknown handles, duplicates
// and equal expiries. It is followed by random insert/adjust/delete/tick
// traffic, with fill bursts that run the table full and at times drain it again.
// ----------------------------------------------------------------------------
module testbench;
    import stq_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 250;

    // scoreboard: sorted timer list and the result words it implies
    class timer_list_checker;
        logic [IN_TIME_W-1:0] expiry_list[$];
        logic [HANDLE_W-1:0]  handle_list[$];
        stq_out_t             expected_words[$];
        int                   errors = 0;

        function int find_timer(logic [HANDLE_W-1:0] h);
            for (int i = 0; i < handle_list.size(); i++)
                if (handle_list[i] == h)
                    return i;
            return -1;
        endfunction

        // new timer goes after every equal or earlier expiry
        function void place_timer(logic [HANDLE_W-1:0] h, logic [IN_TIME_W-1:0] t);
            int pos;
            pos = 0;
            while (pos < expiry_list.size() && expiry_list[pos] <= t)
                pos++;
            expiry_list.insert(pos, t);
            handle_list.insert(pos, h);
        endfunction

        function void push_ack(stq_status_t st);
            stq_out_t r;
            r = '0;
            r.kind      = KIND_ACK;
            r.status    = st;
            r.last      = 1'b1;
            r.occupancy = OCC_W'(handle_list.size());
            expected_words.push_back(r);
        endfunction

        // accepted request word: update the list, queue the result words
        function void note_request(stq_in_t w);
            int       pos;
            int       n;
            stq_out_t r;
            case (w.op)
                OP_INSERT:
                begin
                    if (find_timer(w.handle) >= 0)
                        push_ack(ST_DUPLICATE);
                    else if (handle_list.size() >= TABLE_DEPTH)
                        push_ack(ST_FULL);
                    else
                    begin
                        place_timer(w.handle, w.expire);
                        push_ack(ST_OK);
                    end
                end
                OP_ADJUST, OP_DELETE:
                begin
                    pos = find_timer(w.handle);
                    if (pos < 0)
                        push_ack(ST_NOT_FOUND);
                    else
                    begin
                        expiry_list.delete(pos);
                        handle_list.delete(pos);
                        if (w.op == OP_ADJUST)
                            place_timer(w.handle, w.expire);
                        push_ack(ST_OK);
                    end
                end
                default:
                begin
                    n = 0;
                    while (expiry_list.size() > 0 && expiry_list[0] <= w.now)
                    begin
                        r = '0;
                        r.kind           = KIND_EXPIRED;
                        r.expired_handle = handle_list[0];
                        expiry_list.delete(0);
                        handle_list.delete(0);
                        r.status    = ST_OK;
                        r.last      = (expiry_list.size() == 0 || expiry_list[0] > w.now);
                        r.occupancy = OCC_W'(handle_list.size());
                        expected_words.push_back(r);
                        n++;
                    end
                    if (n == 0)
                    begin
                        r = '0;
                        r.kind      = KIND_NONE;
                        r.last      = 1'b1;
                        r.occupancy = OCC_W'(handle_list.size());
                        expected_words.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, seen);
            end
        endfunction

        // result word seen at a clock edge
        function void check_result(stq_out_t got);
            stq_out_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_words.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("expired_handle", 32'(want.expired_handle),
                          32'(got.expired_handle));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    stq_in_t  request;
    logic     result_valid;
    stq_out_t result;

    timer_list_checker    timers;
    int                   sent_items;
    logic [IN_TIME_W-1:0] wall_clock;
    logic [HANDLE_W-1:0]  handle_pool[20];

    sorted_timer_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            timers.check_result(result);
    end

    // run limit
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic stq_in_t make_word(stq_op_t op, logic [HANDLE_W-1:0] h,
                                          logic [IN_TIME_W-1:0] t_exp,
                                          logic [IN_TIME_W-1:0] t_now);
        stq_in_t w;
        w.op     = op;
        w.handle = h;
        w.expire = t_exp;
        w.now    = t_now;
        return w;
    endfunction

    // drive one word at the falling edge, hold until the block takes it
    task automatic send_word(input stq_in_t w);
        bit taken;
        if (!(sent_items >= 80 && sent_items < 150) && $urandom_range(0, 99) < 10)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start   = 1'b1;
        request = w;
        taken   = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        timers.note_request(w);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 99) < 85)
            return handle_pool[$urandom_range(0, 19)];
        return HANDLE_W'($urandom_range(0, 1023));
    endfunction

    // adjust and delete mostly name a timer that is held
    function automatic logic [HANDLE_W-1:0] pick_held_handle();
        if (timers.handle_list.size() > 0 && $urandom_range(0, 99) < 70)
            return timers.handle_list[$urandom_range(0, timers.handle_list.size() - 1)];
        return pick_handle();
    endfunction

    function automatic logic [IN_TIME_W-1:0] pick_expire();
        if ($urandom_range(0, 99) < 85)
            return wall_clock + $urandom_range(0, 120);
        return $urandom;
    endfunction

    function automatic logic [IN_TIME_W-1:0] pick_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            wall_clock = wall_clock + $urandom_range(0, 50);
            return wall_clock;
        end
        if (r < 90)
            return $urandom;
        if (r < 95)
            return '0;
        return '1;
    endfunction

    task automatic send_random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_word(make_word(OP_INSERT, pick_handle(), pick_expire(), $urandom));
        else if (r < 55)
            send_word(make_word(OP_ADJUST, pick_held_handle(), pick_expire(), $urandom));
        else if (r < 70)
            send_word(make_word(OP_DELETE, pick_held_handle(), $urandom, $urandom));
        else
            send_word(make_word(OP_TICK, pick_handle(), $urandom, pick_now()));
    endtask

    // stimulus
    initial
    begin
        int wait_cycles;
        int burst;

        timers     = new();
        sent_items = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        wall_clock = $urandom;
        foreach (handle_pool[i])
            handle_pool[i] = HANDLE_W'($urandom_range(0, 1023));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, unknown handles, extremes, equal expiries
        send_word(make_word(OP_TICK, 10'd0, 32'd0, 32'd0));
        send_word(make_word(OP_DELETE, 10'd5, 32'd0, 32'd0));
        send_word(make_word(OP_ADJUST, 10'd5, 32'd9, 32'd0));
        send_word(make_word(OP_INSERT, 10'd0, 32'd0, 32'hFFFF_FFFF));
        send_word(make_word(OP_INSERT, 10'd1023, 32'hFFFF_FFFF, 32'd0));
        send_word(make_word(OP_INSERT, 10'd0, 32'd7, 32'd0));
        send_word(make_word(OP_INSERT, 10'd5, 32'd100, 32'd0));
        send_word(make_word(OP_INSERT, 10'd6, 32'd100, 32'd0));
        send_word(make_word(OP_INSERT, 10'd7, 32'd100, 32'd0));
        send_word(make_word(OP_ADJUST, 10'd7, 32'd50, 32'd0));
        send_word(make_word(OP_ADJUST, 10'd5, 32'd100, 32'd0));
        send_word(make_word(OP_ADJUST, 10'd0, 32'd200, 32'd0));
        send_word(make_word(OP_DELETE, 10'd6, 32'd0, 32'd0));
        send_word(make_word(OP_TICK, 10'd0, 32'd0, 32'd49));
        send_word(make_word(OP_TICK, 10'd0, 32'd0, 32'd100));
        send_word(make_word(OP_TICK, 10'd0, 32'd0, 32'hFFFF_FFFE));
        send_word(make_word(OP_TICK, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(OP_TICK, 10'd0, 32'd0, 32'd0));

        // random: fill bursts that run the table full, and mixed bursts
        burst = 0;
        while (sent_items < RANDOM_ITEMS + 18)
        begin
            if (burst == 0 || $urandom_range(0, 9) < 2)
            begin
                repeat (18)
                    send_word(make_word(OP_INSERT, pick_handle(), pick_expire(), $urandom));
                if ($urandom_range(0, 1) == 0)
                    send_word(make_word(OP_TICK, pick_handle(), $urandom, '1));
            end
            else
            begin
                repeat (20)
                    send_random_word();
            end
            burst++;
        end
        start = 1'b0;

        // drain the outstanding result words
        wait_cycles = 0;
        while (timers.expected_words.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (timers.expected_words.size() != 0)
        begin
            timers.errors++;
            $display("%0t: %0d result words never arrived, expected %h, actual none",
                     $time, timers.expected_words.size(), timers.expected_words[0]);
        end

        if (timers.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/stq_pkg.sv
rtl/core/stq_datapath.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timer_queue.sv
rtl/core/stq_checker.sv
verif/testbench.sv
